// ----- rtl/core/cnsc_pkg.sv -----
`timescale 1ns / 1ps

package cnsc_pkg;

    // request opcodes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_RESP  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_SDO  = 2'd0;
    localparam logic [1:0] KIND_NMT  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_FIRST_ID = 2'd0;
    localparam logic [1:0] CFG_LAST_ID  = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT  = 2'd2;
    localparam logic [1:0] CFG_ATTEMPTS = 2'd3;

    localparam int CFG_DATA_W = 16;

    // reset values of the configuration registers
    localparam logic [6:0]  FIRST_ID_RST = 7'd1;
    localparam logic [6:0]  LAST_ID_RST  = 7'd127;
    localparam logic [15:0] TIMEOUT_RST  = 16'd100;
    localparam logic [3:0]  ATTEMPTS_RST = 4'd3;

    // CANopen identifiers and payload bytes
    localparam logic [10:0] SDO_RX_BASE     = 11'h600;
    localparam logic [10:0] NMT_COB_ID      = 11'h000;
    localparam logic [7:0]  SDO_UPLOAD_CMD  = 8'h40;
    localparam logic [7:0]  NMT_CMD_START   = 8'h01;
    localparam logic [3:0]  SDO_LEN         = 4'd8;
    localparam logic [3:0]  NMT_LEN         = 4'd2;
    localparam logic [15:0] OBJ_DEVICE_TYPE = 16'h1000;
    localparam logic [15:0] OBJ_ERROR_REG   = 16'h1001;
    localparam logic [15:0] OBJ_IDENTITY    = 16'h1018;

    localparam logic [7:0] FOUND_MAX = 8'd255;

    typedef struct packed {
        logic [1:0] opcode;
        logic [6:0] responder_id;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [10:0] frame_id;
        logic [3:0]  frame_len;
        logic [63:0] frame_data;
        logic [7:0]  found_total;
        logic [6:0]  probe_node;
        logic        last;
    } out_item_t;

    // object index rotates with attempt mod 3
    function automatic logic [15:0] probe_object(input logic [3:0] attempt);
        logic [15:0] obj;
        case (attempt)
            4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: obj = OBJ_DEVICE_TYPE;
            4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       obj = OBJ_ERROR_REG;
            default:                              obj = OBJ_IDENTITY;
        endcase
        return obj;
    endfunction

    function automatic out_item_t make_sdo(input logic [6:0] node,
                                           input logic [3:0] attempt,
                                           input logic [7:0] found);
        out_item_t   r;
        logic [15:0] obj;
        obj           = probe_object(attempt);
        r.result_kind = KIND_SDO;
        r.frame_id    = SDO_RX_BASE + {4'd0, node};
        r.frame_len   = SDO_LEN;
        r.frame_data  = {40'd0, obj[15:8], obj[7:0], SDO_UPLOAD_CMD};
        r.found_total = found;
        r.probe_node  = node;
        r.last        = 1'b0;
        return r;
    endfunction

    function automatic out_item_t make_nmt(input logic [6:0] node,
                                           input logic [7:0] found);
        out_item_t r;
        r.result_kind = KIND_NMT;
        r.frame_id    = NMT_COB_ID;
        r.frame_len   = NMT_LEN;
        r.frame_data  = {48'd0, 1'b0, node, NMT_CMD_START};
        r.found_total = found;
        r.probe_node  = node;
        r.last        = 1'b0;
        return r;
    endfunction

    function automatic out_item_t make_done(input logic [7:0] found);
        out_item_t r;
        r.result_kind = KIND_DONE;
        r.frame_id    = '0;
        r.frame_len   = '0;
        r.frame_data  = '0;
        r.found_total = found;
        r.probe_node  = '0;
        r.last        = 1'b0;
        return r;
    endfunction

endpackage

// ----- rtl/core/cnsc_result_queue.sv -----
`timescale 1ns / 1ps

module cnsc_result_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [1:0]          push_cnt,
    input  cnsc_pkg::out_item_t push0,
    input  cnsc_pkg::out_item_t push1,
    output logic                room_for_two,
    output logic                m_valid,
    input  logic                m_ready,
    output cnsc_pkg::out_item_t m_data
);
    import cnsc_pkg::*;

    out_item_t   slot_reg [4];
    logic [1:0]  wr_ptr_reg, wr_ptr_next;
    logic [1:0]  rd_ptr_reg, rd_ptr_next;
    logic [2:0]  count_reg, count_next;
    logic        pop;

    assign pop          = m_valid && m_ready;
    assign m_valid      = (count_reg != 3'd0);
    assign m_data       = slot_reg[rd_ptr_reg];
    assign room_for_two = (count_reg < 3'd3);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + push_cnt;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push_cnt} - {2'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            slot_reg[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2) begin
            slot_reg[wr_ptr_reg + 2'd1] <= push1;
        end
    end

endmodule

// ----- rtl/core/canopen_node_scan_sequencer.sv -----
`timescale 1ns / 1ps
// results are written into the result queue when their request is accepted and are offered on the m_ side from there
// one request per cycle while s_ready is high; a request with two results queues both, offered one after the other
// the input side stalls only when the four-entry result queue has room for fewer than two
// reset: aresetn synchronous, active low; clears scan state and the result queue,
// configuration registers return to first 1, last 127, timeout 100, attempts 3

module canopen_node_scan_sequencer (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration write port
    input  logic                        cfg_wr_en,
    input  logic [1:0]                  cfg_index,
    input  logic [cnsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // request channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  cnsc_pkg::in_item_t          s_data,
    // result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output cnsc_pkg::out_item_t         m_data
);
    import cnsc_pkg::*;

    // configuration registers
    logic [6:0]  first_id_reg;
    logic [6:0]  last_id_reg;
    logic [15:0] timeout_reg;
    logic [3:0]  attempts_reg;

    // scan state
    logic        active_reg,  active_next;
    logic [7:0]  node_reg,    node_next;
    logic [3:0]  attempt_reg, attempt_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [7:0]  found_reg,   found_next;

    logic        s_accept;
    logic        room_for_two;
    logic [7:0]  node_inc;
    logic [3:0]  attempt_inc;
    logic [16:0] elapsed_inc;
    logic [1:0]  push_cnt;
    out_item_t   res0, res1;

    assign s_ready  = room_for_two;
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_id_reg <= FIRST_ID_RST;
            last_id_reg  <= LAST_ID_RST;
            timeout_reg  <= TIMEOUT_RST;
            attempts_reg <= ATTEMPTS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FIRST_ID: first_id_reg <= cfg_wdata[6:0];
                CFG_LAST_ID:  last_id_reg  <= cfg_wdata[6:0];
                CFG_TIMEOUT:  timeout_reg  <= cfg_wdata[15:0];
                CFG_ATTEMPTS: attempts_reg <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // one pass of the scan step: next state plus up to two results
    always_comb begin
        active_next  = active_reg;
        node_next    = node_reg;
        attempt_next = attempt_reg;
        elapsed_next = elapsed_reg;
        found_next   = found_reg;
        push_cnt     = 2'd0;
        res0         = '0;
        res1         = '0;

        node_inc    = node_reg + 8'd1;
        attempt_inc = attempt_reg + 4'd1;
        elapsed_inc = {1'b0, elapsed_reg} + 17'd1;

        if (s_accept) begin
            case (s_data.opcode)
                OP_START: begin
                    // a start while scanning simply restarts
                    active_next  = 1'b1;
                    node_next    = {1'b0, first_id_reg};
                    attempt_next = '0;
                    elapsed_next = '0;
                    found_next   = '0;
                end
                OP_TICK: begin
                    if (active_reg) begin
                        if (elapsed_inc > {1'b0, timeout_reg}) begin
                            if (attempt_inc >= attempts_reg) begin
                                // attempts used up: move to the next node
                                attempt_next = '0;
                                node_next    = node_inc;
                                if (node_inc > {1'b0, last_id_reg}) begin
                                    active_next  = 1'b0;
                                    node_next    = '0;
                                    elapsed_next = '0;
                                    res0         = make_done(found_reg);
                                    push_cnt     = 2'd1;
                                end else begin
                                    // new node: sdo read then nmt start
                                    elapsed_next = '0;
                                    res0         = make_sdo(node_inc[6:0], 4'd0, found_reg);
                                    res1         = make_nmt(node_inc[6:0], found_reg);
                                    push_cnt     = 2'd2;
                                end
                            end else begin
                                // retry the same node with the next object
                                attempt_next = attempt_inc;
                                elapsed_next = '0;
                                res0         = make_sdo(node_reg[6:0], attempt_inc, found_reg);
                                push_cnt     = 2'd1;
                            end
                        end else begin
                            elapsed_next = elapsed_inc[15:0];
                        end
                    end
                end
                OP_RESP: begin
                    if (active_reg && (s_data.responder_id >= first_id_reg)
                        && (s_data.responder_id <= last_id_reg)) begin
                        if (found_reg != FOUND_MAX) begin
                            found_next = found_reg + 8'd1;
                        end
                        // the probed node answered: advance without a frame
                        if ({1'b0, s_data.responder_id} == node_reg) begin
                            attempt_next = '0;
                            node_next    = node_inc;
                            elapsed_next = '0;
                            if (node_inc > {1'b0, last_id_reg}) begin
                                active_next = 1'b0;
                                node_next   = '0;
                                res0        = make_done(found_next);
                                push_cnt    = 2'd1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end

        // flag the final result of this request
        if (push_cnt == 2'd1) begin
            res0.last = 1'b1;
        end
        if (push_cnt == 2'd2) begin
            res1.last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            node_reg    <= '0;
            attempt_reg <= '0;
            elapsed_reg <= '0;
            found_reg   <= '0;
        end else begin
            active_reg  <= active_next;
            node_reg    <= node_next;
            attempt_reg <= attempt_next;
            elapsed_reg <= elapsed_next;
            found_reg   <= found_next;
        end
    end

    // results wait here so the request side keeps flowing
    cnsc_result_queue u_result_queue (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push_cnt     (push_cnt),
        .push0        (res0),
        .push1        (res1),
        .room_for_two (room_for_two),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

endmodule
